// File: src/tce_pkg.sv
`timescale 1ns / 1ps
package tce_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;
	localparam int ADDR_W  = $clog2(CELLS);

	localparam logic [7:0] RESET_ATTR = 8'h07;
	localparam logic [7:0] CH_BLANK   = 8'h20;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_BS      = 8'h08;
	localparam logic [7:0] CH_TAB     = 8'h09;

	typedef enum logic [2:0] {
		OP_PUT_CURSOR    = 3'd0,
		OP_PUT_CELL      = 3'd1,
		OP_PUT_CELL_ATTR = 3'd2,
		OP_SET_CURSOR    = 3'd3,
		OP_CLEAR         = 3'd4,
		OP_CLEAR_LINE    = 3'd5,
		OP_READ          = 3'd6
	} op_t;

	typedef struct packed {
		logic [7:0] attr;
		logic [7:0] chr;
	} cell_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		cell_t             data;
	} wr_req_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} rd_req_t;

endpackage

// File: src/tce_if.sv
`timescale 1ns / 1ps
interface tce_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic [7:0] char_code;
	logic [7:0] column;
	logic [7:0] row;
	logic [7:0] attribute;

	modport source (output valid, operation, char_code, column, row, attribute, input ready);
	modport sink (input valid, operation, char_code, column, row, attribute, output ready);
endinterface

interface tce_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  cursor_col;
	logic [7:0]  cursor_line;
	logic [15:0] cursor_offset;
	logic [7:0]  cell_char;
	logic [7:0]  cell_attribute;
	logic        scrolled;
	logic        ignored;

	modport source (output valid, cursor_col, cursor_line, cursor_offset, cell_char,
		cell_attribute, scrolled, ignored, input ready);
	modport sink (input valid, cursor_col, cursor_line, cursor_offset, cell_char,
		cell_attribute, scrolled, ignored, output ready);
endinterface

interface tce_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_attribute;

	modport source (output valid, text_attribute, input ready);
	modport sink (input valid, text_attribute, output ready);
endinterface

// File: src/tce_cell_store.sv
`timescale 1ns / 1ps
module tce_cell_store
	import tce_pkg::*;
(
	input  logic    clk,
	input  wr_req_t wr,
	input  rd_req_t rd,
	output cell_t   rd_data
);

	cell_t mem_q [CELLS];
	cell_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data_q <= mem_q[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/text_console_engine.sv
`timescale 1ns / 1ps
// Channel  Modport  Beat
// cmd      sink     operation, char_code, column, row, attribute
// rsp      source   cursor_col, cursor_line, cursor_offset, cell_char, cell_attribute,
//                   scrolled, ignored
// cfg      sink     text_attribute (always ready)
//
// Put and set cursor (no scroll) pass the decode, execute and offset states, the result
// registered in the offset state; a read adds a read-wait state after execute.
// Scroll: a copy pass moving rows 1 to ROWS-1 up one row, a drain state, then blanking of
// the last row, on the single cell store port pair. Clear screen blanks every cell; clear
// line blanks one row. After reset the store is blanked with cmd not ready.
// One command at a time; a held result stalls only the final offset step.
module text_console_engine
	import tce_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	tce_cmd_if.sink   cmd,
	tce_rsp_if.source rsp,
	tce_cfg_if.sink   cfg
);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_DECODE, S_EXEC, S_RDWAIT, S_COPY, S_DRAIN, S_BLANK, S_OFFSET
	} state_t;

	state_t state_q;

	op_t               op_q;
	logic [7:0]        ch_q, col_q, row_q, attr_q;
	logic [7:0]        text_attr_q;
	logic [7:0]        cur_x_q, cur_y_q;
	logic [ADDR_W-1:0] addr_q, cnt_q;
	cell_t             wdata_q;
	logic              wr_q, rd_q, blank_q, scroll_q, ign_q;
	logic [7:0]        rd_char_q, rd_attr_q;
	logic              cp_valid_s1;
	logic [ADDR_W-1:0] cp_dst_s1;

	logic              out_valid_q;
	logic [7:0]        out_col_q, out_line_q, out_char_q, out_attr_q;
	logic [15:0]       out_off_q;
	logic              out_scr_q, out_ign_q;

	// decode
	logic [8:0]        nx, ny, tab_x;
	logic [7:0]        mrow, mcol, wcol, wchr;
	logic              d_wr, d_rd, d_blank, d_scroll, d_ign;
	logic [ADDR_W-1:0] d_cnt;
	cell_t             d_wdata;
	logic              on_screen, row_ok;

	// shared multiply-add
	logic [7:0]        mul_row, mul_col;
	logic [15:0]       mul_res;

	wr_req_t           wr;
	rd_req_t           rd;
	cell_t             rd_data;

	assign row_ok    = {1'b0, row_q} < 9'(ROWS);
	assign on_screen = row_ok && ({1'b0, col_q} < 9'(COLUMNS));
	assign tab_x     = ({1'b0, cur_x_q} + 9'd8) & ~9'd7;

	always_comb begin
		nx       = {1'b0, cur_x_q};
		ny       = {1'b0, cur_y_q};
		mrow     = row_q;
		mcol     = col_q;
		wcol     = cur_x_q;
		wchr     = ch_q;
		d_wr     = 1'b0;
		d_rd     = 1'b0;
		d_blank  = 1'b0;
		d_scroll = 1'b0;
		d_ign    = 1'b0;
		d_cnt    = ADDR_W'(COLUMNS - 1);
		d_wdata  = '{attr: text_attr_q, chr: ch_q};
		case (op_q)
			OP_PUT_CURSOR: begin
				case (ch_q)
					CH_LF: begin
						nx = 9'd0;
						ny = {1'b0, cur_y_q} + 9'd1;
					end
					CH_CR: nx = 9'd0;
					CH_BS: begin
						if (cur_x_q != 8'd0) begin
							nx   = {1'b0, cur_x_q} - 9'd1;
							wcol = cur_x_q - 8'd1;
							wchr = CH_BLANK;
							d_wr = 1'b1;
						end
					end
					CH_TAB: begin
						if (tab_x >= 9'(COLUMNS)) begin
							nx = 9'd0;
							ny = {1'b0, cur_y_q} + 9'd1;
						end else begin
							nx = tab_x;
						end
					end
					default: begin
						nx   = {1'b0, cur_x_q} + 9'd1;
						d_wr = 1'b1;
					end
				endcase
				if (nx >= 9'(COLUMNS)) begin
					nx = 9'd0;
					ny = ny + 9'd1;
				end
				if (ny >= 9'(ROWS)) begin
					ny       = 9'(ROWS - 1);
					d_scroll = 1'b1;
				end
				mrow    = cur_y_q;
				mcol    = wcol;
				d_wdata = '{attr: text_attr_q, chr: wchr};
			end
			OP_PUT_CELL, OP_PUT_CELL_ATTR: begin
				d_wr  = on_screen;
				d_ign = !on_screen;
				if (op_q == OP_PUT_CELL_ATTR) begin
					d_wdata = '{attr: attr_q, chr: ch_q};
				end
			end
			OP_SET_CURSOR: begin
				nx = ({1'b0, col_q} < 9'(COLUMNS)) ? {1'b0, col_q} : 9'(COLUMNS - 1);
				ny = row_ok ? {1'b0, row_q} : 9'(ROWS - 1);
			end
			OP_CLEAR: begin
				nx      = 9'd0;
				ny      = 9'd0;
				mrow    = 8'd0;
				mcol    = 8'd0;
				d_blank = 1'b1;
				d_cnt   = ADDR_W'(CELLS - 1);
			end
			OP_CLEAR_LINE: begin
				mcol    = 8'd0;
				d_blank = row_ok;
				d_ign   = !row_ok;
			end
			OP_READ: d_rd = on_screen;
			default: ;
		endcase
	end

	assign mul_row = (state_q == S_OFFSET) ? cur_y_q : mrow;
	assign mul_col = (state_q == S_OFFSET) ? cur_x_q : mcol;
	assign mul_res = ({8'd0, mul_row} * 16'(COLUMNS)) + {8'd0, mul_col};

	always_comb begin
		wr = '{en: 1'b0, addr: addr_q, data: wdata_q};
		case (state_q)
			S_INIT:  wr = '{en: 1'b1, addr: addr_q, data: '{attr: RESET_ATTR, chr: CH_BLANK}};
			S_EXEC:  wr.en = wr_q;
			S_COPY, S_DRAIN: wr = '{en: cp_valid_s1, addr: cp_dst_s1, data: rd_data};
			S_BLANK: wr = '{en: 1'b1, addr: addr_q, data: '{attr: text_attr_q, chr: CH_BLANK}};
			default: ;
		endcase
		rd.en   = (state_q == S_COPY) || ((state_q == S_EXEC) && rd_q);
		rd.addr = addr_q;
	end

	tce_cell_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attr_q <= RESET_ATTR;
		end else if (cfg.valid) begin
			text_attr_q <= cfg.text_attribute;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			op_q        <= OP_PUT_CURSOR;
			ch_q        <= 8'd0;
			col_q       <= 8'd0;
			row_q       <= 8'd0;
			attr_q      <= 8'd0;
			cur_x_q     <= 8'd0;
			cur_y_q     <= 8'd0;
			addr_q      <= '0;
			cnt_q       <= ADDR_W'(CELLS - 1);
			wdata_q     <= '0;
			wr_q        <= 1'b0;
			rd_q        <= 1'b0;
			blank_q     <= 1'b0;
			scroll_q    <= 1'b0;
			ign_q       <= 1'b0;
			rd_char_q   <= 8'd0;
			rd_attr_q   <= 8'd0;
			cp_valid_s1 <= 1'b0;
			cp_dst_s1   <= '0;
			out_valid_q <= 1'b0;
			out_col_q   <= 8'd0;
			out_line_q  <= 8'd0;
			out_off_q   <= 16'd0;
			out_char_q  <= 8'd0;
			out_attr_q  <= 8'd0;
			out_scr_q   <= 1'b0;
			out_ign_q   <= 1'b0;
		end else begin
			if (rsp.ready && (state_q != S_OFFSET)) begin
				out_valid_q <= 1'b0;
			end
			cp_valid_s1 <= (state_q == S_COPY);
			cp_dst_s1   <= addr_q - ADDR_W'(COLUMNS);
			case (state_q)
				S_INIT: begin
					addr_q <= addr_q + ADDR_W'(1);
					cnt_q  <= cnt_q - ADDR_W'(1);
					if (cnt_q == '0) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd.valid) begin
						op_q    <= op_t'(cmd.operation);
						ch_q    <= cmd.char_code;
						col_q   <= cmd.column;
						row_q   <= cmd.row;
						attr_q  <= cmd.attribute;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					cur_x_q   <= nx[7:0];
					cur_y_q   <= ny[7:0];
					addr_q    <= mul_res[ADDR_W-1:0];
					cnt_q     <= d_cnt;
					wdata_q   <= d_wdata;
					wr_q      <= d_wr;
					rd_q      <= d_rd;
					blank_q   <= d_blank;
					scroll_q  <= d_scroll;
					ign_q     <= d_ign;
					rd_char_q <= 8'd0;
					rd_attr_q <= 8'd0;
					state_q   <= S_EXEC;
				end
				S_EXEC: begin
					if (rd_q) begin
						state_q <= S_RDWAIT;
					end else if (scroll_q) begin
						addr_q  <= ADDR_W'(COLUMNS);
						cnt_q   <= ADDR_W'(CELLS - COLUMNS - 1);
						state_q <= S_COPY;
					end else if (blank_q) begin
						state_q <= S_BLANK;
					end else begin
						state_q <= S_OFFSET;
					end
				end
				S_RDWAIT: begin
					rd_char_q <= rd_data.chr;
					rd_attr_q <= rd_data.attr;
					state_q   <= S_OFFSET;
				end
				S_COPY: begin
					addr_q <= addr_q + ADDR_W'(1);
					cnt_q  <= cnt_q - ADDR_W'(1);
					if (cnt_q == '0) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// last row refilled with blanks
					addr_q  <= ADDR_W'(CELLS - COLUMNS);
					cnt_q   <= ADDR_W'(COLUMNS - 1);
					state_q <= S_BLANK;
				end
				S_BLANK: begin
					addr_q <= addr_q + ADDR_W'(1);
					cnt_q  <= cnt_q - ADDR_W'(1);
					if (cnt_q == '0) begin
						state_q <= S_OFFSET;
					end
				end
				S_OFFSET: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_col_q   <= cur_x_q;
						out_line_q  <= cur_y_q;
						out_off_q   <= mul_res;
						out_char_q  <= rd_char_q;
						out_attr_q  <= rd_attr_q;
						out_scr_q   <= scroll_q;
						out_ign_q   <= ign_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd.ready          = (state_q == S_IDLE);
	assign cfg.ready          = 1'b1;
	assign rsp.valid          = out_valid_q;
	assign rsp.cursor_col     = out_col_q;
	assign rsp.cursor_line    = out_line_q;
	assign rsp.cursor_offset  = out_off_q;
	assign rsp.cell_char      = out_char_q;
	assign rsp.cell_attribute = out_attr_q;
	assign rsp.scrolled       = out_scr_q;
	assign rsp.ignored        = out_ign_q;

`ifndef SYNTHESIS
	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cur_x_q} < 9'(COLUMNS)) && ({1'b0, cur_y_q} < 9'(ROWS)))
		else $error("cursor left the screen");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> ({1'b0, wr.addr} < (ADDR_W + 1)'(CELLS)))
		else $error("cell write beyond store");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !cmd.ready)
		else $error("second beat taken while busy");

	a_scroll_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.scrolled) |-> (rsp.cursor_line == 8'(ROWS - 1)))
		else $error("scroll left cursor off the last row");

	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.ignored) |-> (rsp.cell_char == 8'd0 && rsp.cell_attribute == 8'd0))
		else $error("cell data on a non-read beat");
`endif

endmodule

// File: tb/tce_console_checker.sv
`timescale 1ns / 1ps
module tce_console_checker
	import tce_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	tce_cmd_if          cmd,
	tce_rsp_if          rsp,
	tce_cfg_if          cfg,
	output int unsigned mismatches,
	output int unsigned awaited
);

	typedef struct packed {
		logic [7:0]  col;
		logic [7:0]  line;
		logic [15:0] offset;
		logic [7:0]  chr;
		logic [7:0]  attr;
		logic        scrolled;
		logic        ignored;
	} console_status_t;

	cell_t           screen [CELLS];
	logic [7:0]      cur_col;
	logic [7:0]      cur_row;
	logic [7:0]      text_attr;
	console_status_t status_q [$];

	function automatic void blank_row(input int r);
		for (int c = 0; c < COLUMNS; c++)
			screen[r * COLUMNS + c] = '{attr: text_attr, chr: CH_BLANK};
	endfunction

	function automatic void scroll_screen();
		for (int i = 0; i < CELLS - COLUMNS; i++)
			screen[i] = screen[i + COLUMNS];
		blank_row(ROWS - 1);
	endfunction

	// returns 1 when the screen scrolled
	function automatic logic put_at_cursor(input logic [7:0] ch);
		int   x;
		int   y;
		logic rolled;
		x = cur_col;
		y = cur_row;
		rolled = 1'b0;
		case (ch)
			CH_LF: begin
				x = 0;
				y++;
			end
			CH_CR: x = 0;
			CH_BS: begin
				if (x > 0) begin
					x--;
					screen[y * COLUMNS + x] = '{attr: text_attr, chr: CH_BLANK};
				end
			end
			CH_TAB: begin
				x = (x + 8) & ~7;
				if (x >= COLUMNS) begin
					x = 0;
					y++;
				end
			end
			default: begin
				screen[y * COLUMNS + x] = '{attr: text_attr, chr: ch};
				x++;
			end
		endcase
		if (x >= COLUMNS) begin
			x = 0;
			y++;
		end
		if (y >= ROWS) begin
			scroll_screen();
			y = ROWS - 1;
			rolled = 1'b1;
		end
		cur_col = 8'(x);
		cur_row = 8'(y);
		return rolled;
	endfunction

	function automatic console_status_t predict_status(input logic [2:0] op,
		input logic [7:0] ch, input logic [7:0] col, input logic [7:0] row,
		input logic [7:0] attr);
		console_status_t s;
		logic            on_screen;
		int              idx;
		s = '0;
		on_screen = (int'(col) < COLUMNS) && (int'(row) < ROWS);
		idx = int'(row) * COLUMNS + int'(col);
		case (op)
			OP_PUT_CURSOR: s.scrolled = put_at_cursor(ch);
			OP_PUT_CELL, OP_PUT_CELL_ATTR: begin
				if (on_screen)
					screen[idx] = '{attr: (op == OP_PUT_CELL) ? text_attr : attr, chr: ch};
				else
					s.ignored = 1'b1;
			end
			OP_SET_CURSOR: begin
				cur_col = (int'(col) < COLUMNS) ? col : 8'(COLUMNS - 1);
				cur_row = (int'(row) < ROWS) ? row : 8'(ROWS - 1);
			end
			OP_CLEAR: begin
				for (int r = 0; r < ROWS; r++)
					blank_row(r);
				cur_col = '0;
				cur_row = '0;
			end
			OP_CLEAR_LINE: begin
				if (int'(row) < ROWS)
					blank_row(int'(row));
				else
					s.ignored = 1'b1;
			end
			OP_READ: begin
				if (on_screen) begin
					s.chr = screen[idx].chr;
					s.attr = screen[idx].attr;
				end
			end
			default: ;
		endcase
		s.col = cur_col;
		s.line = cur_row;
		s.offset = 16'(int'(cur_row) * COLUMNS + int'(cur_col));
		return s;
	endfunction

	function automatic bit field_ok(input string name, input int want, input int got);
		if (want == got)
			return 1'b1;
		$display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		console_status_t want;
		bit              ok;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++)
				screen[i] = '{attr: RESET_ATTR, chr: CH_BLANK};
			cur_col = '0;
			cur_row = '0;
			text_attr = RESET_ATTR;
			status_q.delete();
			mismatches <= 0;
			awaited <= 0;
		end else begin
			// result beat is checked before this edge's command beat is queued
			if (rsp.valid && rsp.ready) begin
				if (status_q.size() == 0) begin
					$display("%0t: result beat with no command outstanding", $time);
					mismatches <= mismatches + 1;
				end else begin
					want = status_q.pop_front();
					ok = field_ok("cursor_col", want.col, rsp.cursor_col)
						& field_ok("cursor_line", want.line, rsp.cursor_line)
						& field_ok("cursor_offset", want.offset, rsp.cursor_offset)
						& field_ok("cell_char", want.chr, rsp.cell_char)
						& field_ok("cell_attribute", want.attr, rsp.cell_attribute)
						& field_ok("scrolled", want.scrolled, rsp.scrolled)
						& field_ok("ignored", want.ignored, rsp.ignored);
					if (!ok)
						mismatches <= mismatches + 1;
				end
			end
			if (cfg.valid && cfg.ready)
				text_attr = cfg.text_attribute;
			if (cmd.valid && cmd.ready)
				status_q.push_back(predict_status(cmd.operation, cmd.char_code,
					cmd.column, cmd.row, cmd.attribute));
			awaited <= status_q.size();
		end
	end

endmodule

// File: tb/text_console_engine_test.sv
`timescale 1ns / 1ps
module text_console_engine_test;
	import tce_pkg::*;

	localparam logic [2:0] OP_UNUSED    = 3'd7;
	localparam int         RANDOM_ITEMS = 2000;
	localparam int         PHASES       = 6;
	localparam int         LONG_HOLD    = 400;
	localparam int         IDLE_LIMIT   = 20000;
	localparam int         TAIL_CYCLES  = 40;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        long_hold_wanted;
	int unsigned mismatches;
	int unsigned awaited;
	int          idle_cycles = 0;
	int          items_sent = 0;
	logic [7:0]  attr_plan [PHASES];

	tce_cmd_if cmd_ch ();
	tce_rsp_if rsp_ch ();
	tce_cfg_if cfg_ch ();

	always #1 clk = ~clk;

	text_console_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	tce_console_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.rsp        (rsp_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.awaited    (awaited)
	);

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] text_byte();
		int p;
		p = $urandom_range(0, 99);
		if (p < 65)
			return 8'($urandom_range(8'h20, 8'h7E));
		if (p < 75)
			return CH_LF;
		if (p < 80)
			return CH_CR;
		if (p < 86)
			return CH_BS;
		if (p < 92)
			return CH_TAB;
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] pick_col();
		if ($urandom_range(0, 9) != 0)
			return 8'($urandom_range(0, COLUMNS - 1));
		return 8'($urandom_range(COLUMNS, 255));
	endfunction

	function automatic logic [7:0] pick_row();
		if ($urandom_range(0, 9) != 0)
			return 8'($urandom_range(0, ROWS - 1));
		return 8'($urandom_range(ROWS, 255));
	endfunction

	// leaves valid high unless a gap is picked, which lowers it; else the caller lowers it
	task automatic send_cmd(input logic [2:0] op, input logic [7:0] ch,
		input logic [7:0] col, input logic [7:0] row, input logic [7:0] attr);
		int gap;
		cmd_ch.operation <= op;
		cmd_ch.char_code <= ch;
		cmd_ch.column <= col;
		cmd_ch.row <= row;
		cmd_ch.attribute <= attr;
		cmd_ch.valid <= 1'b1;
		do @(posedge clk); while (!cmd_ch.ready);
		items_sent++;
		gap = pick_gap();
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (awaited != 0);
	endtask

	task automatic write_attribute(input logic [7:0] value);
		wait_idle();
		cfg_ch.text_attribute <= value;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic random_sequence();
		int         pick;
		int         n;
		logic [7:0] c;
		logic [7:0] r;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			n = $urandom_range(1, 30);
			repeat (n)
				send_cmd(OP_PUT_CURSOR, text_byte(), 8'($urandom), 8'($urandom), 8'($urandom));
		end else if (pick < 62) begin
			n = $urandom_range(1, 4);
			repeat (n) begin
				c = pick_col();
				r = pick_row();
				send_cmd($urandom_range(0, 1) ? OP_PUT_CELL : OP_PUT_CELL_ATTR,
					8'($urandom), c, r, 8'($urandom));
				send_cmd(OP_READ, 8'($urandom), c, r, 8'($urandom));
			end
		end else if (pick < 74) begin
			n = $urandom_range(1, 6);
			repeat (n)
				send_cmd(OP_READ, 8'($urandom), pick_col(), pick_row(), 8'($urandom));
		end else if (pick < 84) begin
			n = $urandom_range(0, 9);
			if (n < 5)
				r = 8'($urandom_range(ROWS - 3, ROWS - 1));
			else if (n < 8)
				r = 8'($urandom);
			else
				r = 8'($urandom_range(0, ROWS - 1));
			c = (n < 8 && n >= 5) ? 8'($urandom) : 8'($urandom_range(0, COLUMNS - 1));
			send_cmd(OP_SET_CURSOR, 8'($urandom), c, r, 8'($urandom));
		end else if (pick < 89) begin
			send_cmd(OP_CLEAR_LINE, 8'($urandom), 8'($urandom), pick_row(), 8'($urandom));
		end else if (pick < 90) begin
			send_cmd(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		end else if (pick < 93) begin
			send_cmd(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		end else begin
			send_cmd(3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	// receiver: random stalls, plus a long hold-off when asked
	initial begin
		int gap;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold_wanted) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_wanted = 1'b0;
			end
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			gap = pick_gap();
			if (gap != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int phase_end;
		arst_n = 1'b0;
		long_hold_wanted = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.operation = OP_PUT_CURSOR;
		cmd_ch.char_code = '0;
		cmd_ch.column = '0;
		cmd_ch.row = '0;
		cmd_ch.attribute = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.text_attribute = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_PUT_CURSOR, 8'h41, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_PUT_CURSOR, 8'h00, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_PUT_CURSOR, 8'hFF, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_PUT_CURSOR, CH_BS, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_READ, 8'd0, 8'd2, 8'd0, 8'd0);
		send_cmd(OP_PUT_CURSOR, CH_CR, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_PUT_CURSOR, CH_BS, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_PUT_CURSOR, CH_TAB, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_SET_CURSOR, 8'd0, 8'd79, 8'd0, 8'd0);
		send_cmd(OP_PUT_CURSOR, 8'h5A, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_SET_CURSOR, 8'd0, 8'd76, 8'd3, 8'd0);
		send_cmd(OP_PUT_CURSOR, CH_TAB, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_SET_CURSOR, 8'd0, 8'hFF, 8'hFF, 8'd0);
		send_cmd(OP_PUT_CURSOR, 8'h7E, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_SET_CURSOR, 8'd0, 8'd0, 8'd24, 8'd0);
		send_cmd(OP_PUT_CURSOR, CH_LF, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_PUT_CELL, 8'h78, 8'd0, 8'd0, 8'hFF);
		send_cmd(OP_PUT_CELL_ATTR, 8'hC3, 8'd79, 8'd24, 8'hA5);
		send_cmd(OP_PUT_CELL, 8'h11, 8'd80, 8'd0, 8'd0);
		send_cmd(OP_PUT_CELL_ATTR, 8'h22, 8'd0, 8'd25, 8'h5A);
		send_cmd(OP_PUT_CELL_ATTR, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_cmd(OP_READ, 8'd0, 8'd79, 8'd24, 8'd0);
		send_cmd(OP_READ, 8'd0, 8'd80, 8'd0, 8'd0);
		send_cmd(OP_READ, 8'd0, 8'd0, 8'd25, 8'd0);
		send_cmd(OP_CLEAR_LINE, 8'd0, 8'd0, 8'd24, 8'd0);
		send_cmd(OP_CLEAR_LINE, 8'd0, 8'd0, 8'hFF, 8'd0);
		send_cmd(OP_UNUSED, 8'h41, 8'd5, 8'd5, 8'h41);
		send_cmd(OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0);
		send_cmd(OP_READ, 8'd0, 8'd0, 8'd0, 8'd0);

		attr_plan = '{8'h00, 8'hFF, 8'($urandom), 8'h70, 8'($urandom), RESET_ATTR};
		for (int p = 0; p < PHASES; p++) begin
			write_attribute(attr_plan[p]);
			if (p == 1 || p == 4)
				long_hold_wanted = 1'b1;
			phase_end = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < phase_end)
				random_sequence();
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
